FILE: rtl/fir_pkg.sv
// ============================================================================
// fir_pkg
// Shared types and constants for the direct-form FIR filter: payload widths,
// item modes, sequencer states and the MAC control bundle.
// ============================================================================
`default_nettype none

package fir_pkg;

    localparam int FIR_TAPS_DEF = 32;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_IDX_W   = 6;
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int FRAC_BITS    = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_IDX_W-1:0]      coef_idx_t;

    // Item modes
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fir_state_t;

    // Control that travels with one tap's operands into the MAC
    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
    } mac_ctrl_t;

endpackage : fir_pkg

`default_nettype wire

FILE: rtl/fir_in_if.sv
// ============================================================================
// fir_in_if
// Input channel: valid/ready handshake carrying one filter or coefficient item.
// ============================================================================
`default_nettype none

interface fir_in_if import fir_pkg::*; ();

    logic      valid;
    logic      ready;
    logic      mode;
    sample_t   sample_in;
    coef_idx_t coef_index;
    sample_t   coef_value;

    modport source (
        output valid, mode, sample_in, coef_index, coef_value,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_in, coef_index, coef_value,
        output ready
    );

endinterface : fir_in_if

`default_nettype wire

FILE: rtl/fir_out_if.sv
// ============================================================================
// fir_out_if
// Output channel: valid/ready handshake carrying one filtered sample.
// ============================================================================
`default_nettype none

interface fir_out_if import fir_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t filtered_out;

    modport source (
        output valid, filtered_out,
        input  ready
    );

    modport sink (
        input  valid, filtered_out,
        output ready
    );

endinterface : fir_out_if

`default_nettype wire

FILE: rtl/fir_mac.sv
// ============================================================================
// fir_mac
// Shared multiply-accumulate unit: one registered 16x16 product per cycle,
// summed exactly into a wide accumulator.
// ============================================================================
`default_nettype none

module fir_mac import fir_pkg::*; #(
    parameter int TAPS = FIR_TAPS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mac_ctrl_t                           ctrl,
    input  wire sample_t                             coef,
    input  wire sample_t                             samp,
    output logic signed [PROD_W+$clog2(TAPS)-1:0]    acc,
    output logic                                     done
);

    localparam int ACC_W = PROD_W + $clog2(TAPS);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;

    assign prod_next = coef * samp;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg  <= ctrl.vld;
            prod_last_reg <= ctrl.last;
            done_reg      <= prod_vld_reg && prod_last_reg;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule : fir_mac

`default_nettype wire

FILE: rtl/fir_filter_direct_form.sv
// ============================================================================
// fir_filter_direct_form
// Direct-form FIR filter, TAPS taps, Q1.15 samples and coefficients, one
// shared multiply-accumulate unit stepped over the taps by a small sequencer.
// ============================================================================
//
//  Channel    Dir  Handshake      Payload
//  ---------  ---  -------------  --------------------------------------------
//  sample_ch  in   valid / ready  mode, sample_in, coef_index, coef_value
//  result_ch  out  valid / ready  filtered_out
//
//  A coefficient item gives no result; an index of TAPS or more is dropped.
//  A sample item passes from its transfer to its result through TAPS reads
//  of the one coefficient/history port pair feeding the single MAC, then
//  the multiply, accumulate, hand-off and output load steps; sample_ch is
//  ready again on the edge that loads the result.
//  Reset clears the sequencer and the valid bits of both stores; an entry not
//  yet written reads as zero. A stalled result_ch holds the result in the
//  output register; the next item may transfer meanwhile, but its result
//  waits for that register to drain.
// ============================================================================
`default_nettype none

module fir_filter_direct_form import fir_pkg::*; #(
    parameter int TAPS = FIR_TAPS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fir_in_if.sink     sample_ch,
    fir_out_if.source  result_ch
);

    localparam int AW    = $clog2(TAPS);
    localparam int ACC_W = PROD_W + AW;
    localparam int QW    = ACC_W + 1 - FRAC_BITS;

    localparam logic [AW-1:0]         LAST_TAP = AW'(TAPS - 1);
    localparam logic [COEF_IDX_W:0]   TAPS_LIM = (COEF_IDX_W + 1)'(TAPS);
    localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [QW-1:0]  SAT_MAX  = QW'(32767);
    localparam logic signed [QW-1:0]  SAT_MIN  = -QW'(32768);

    // Sequencer
    fir_state_t    state_reg;
    fir_state_t    state_next;
    logic [AW-1:0] tap_cnt_reg;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] wp_reg;

    // Stores: coefficients by tap, sample history as a circular buffer
    sample_t         coef_mem [TAPS];
    sample_t         hist_mem [TAPS];
    logic [TAPS-1:0] coef_vld_reg;
    logic [TAPS-1:0] hist_vld_reg;

    // Read stage
    sample_t rd_coef_reg;
    sample_t rd_hist_reg;
    logic    rd_cv_reg;
    logic    rd_hv_reg;
    logic    rd_vld_reg;
    logic    rd_last_reg;

    // Output register
    logic    out_vld_reg;
    sample_t out_data_reg;

    // Control
    logic      accept;
    logic      take_sample;
    logic      take_coef;
    logic      issue;
    logic      issue_last;
    logic      load_out;
    mac_ctrl_t mac_ctrl;
    sample_t   mac_coef;
    sample_t   mac_samp;

    logic signed [ACC_W-1:0] acc;
    logic                    acc_done;
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [QW-1:0]    q;
    sample_t                 sat_val;

    assign accept      = sample_ch.valid && sample_ch.ready;
    assign take_sample = accept && (sample_ch.mode == MODE_FILTER);
    assign take_coef   = accept && (sample_ch.mode == MODE_COEF)
                         && ({1'b0, sample_ch.coef_index} < TAPS_LIM);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (acc_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        sample_ch.ready = 1'b0;
        issue           = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ch.ready = 1'b1;
            end
            ST_RUN:
            begin
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
                issue = 1'b0;
            end
            ST_DONE:
            begin
                load_out = !out_vld_reg || result_ch.ready;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign issue_last = issue && (tap_cnt_reg == LAST_TAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_cnt_reg  <= '0;
            rp_reg       <= '0;
            wp_reg       <= '0;
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            rd_last_reg <= issue_last;

            if (take_sample)
            begin
                // Newest sample sits at wp; older ones walk down from there
                tap_cnt_reg          <= '0;
                rp_reg               <= wp_reg;
                wp_reg               <= (wp_reg == LAST_TAP) ? '0 : wp_reg + 1'b1;
                hist_vld_reg[wp_reg] <= 1'b1;
            end
            else if (issue)
            begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
                rp_reg      <= (rp_reg == '0) ? LAST_TAP : rp_reg - 1'b1;
            end

            if (take_coef)
            begin
                coef_vld_reg[sample_ch.coef_index[AW-1:0]] <= 1'b1;
            end

            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ---------------- stores and read stage ----------------
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            hist_mem[wp_reg] <= sample_ch.sample_in;
        end
        if (take_coef)
        begin
            coef_mem[sample_ch.coef_index[AW-1:0]] <= sample_ch.coef_value;
        end
        rd_coef_reg <= coef_mem[tap_cnt_reg];
        rd_hist_reg <= hist_mem[rp_reg];
        rd_cv_reg   <= coef_vld_reg[tap_cnt_reg];
        rd_hv_reg   <= hist_vld_reg[rp_reg];
    end

    // Never-written entries read as zero
    assign mac_coef = rd_cv_reg ? rd_coef_reg : '0;
    assign mac_samp = rd_hv_reg ? rd_hist_reg : '0;

    assign mac_ctrl.clr  = take_sample;
    assign mac_ctrl.vld  = rd_vld_reg;
    assign mac_ctrl.last = rd_last_reg;

    fir_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (mac_coef),
        .samp  (mac_samp),
        .acc   (acc),
        .done  (acc_done)
    );

    // ---------------- round half up by 2^15, saturate to 16 bits ----------------
    always_comb
    begin
        rnd_sum = (ACC_W + 1)'(acc) + RND_BIAS;
        q       = $signed(rnd_sum[ACC_W:FRAC_BITS]);
        if (q > SAT_MAX)
        begin
            sat_val = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (q < SAT_MIN)
        begin
            sat_val = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sat_val = q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= sat_val;
        end
    end

    assign result_ch.valid        = out_vld_reg;
    assign result_ch.filtered_out = out_data_reg;

    // ---------------- assertions ----------------
    a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        take_sample |=> state_reg == ST_RUN)
        else $error("sample transfer did not start the tap sweep");

    a_coef_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample_ch.mode == MODE_COEF) |=> state_reg == ST_IDLE)
        else $error("coefficient write left idle");

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done |-> state_reg == ST_DRAIN)
        else $error("accumulator finished outside drain");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished sweep");

    a_no_issue_past_last: assert property (@(posedge clk) disable iff (!rst_n)
        issue_last |=> !issue)
        else $error("tap sweep ran past the last tap");

endmodule : fir_filter_direct_form

`default_nettype wire

FILE: verif/fir_result_checker.sv
// ----------------------------------------------------------------------------
// fir_result_checker
// Watches both channels of the FIR filter, keeps its own copy of the
// coefficient store and the sample history, predicts each filtered sample,
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fir_result_checker import fir_pkg::*; #(
    parameter int TAPS = FIR_TAPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fir_in_if           sample_ch,
    fir_out_if          result_ch,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    sample_t     coef_mem [TAPS];
    sample_t     history  [TAPS-1];
    sample_t     filtered_q [$];
    int unsigned mismatches;
    int unsigned results_seen;

    // Exact sum of the Q2.30 products, round half up by 2^15, saturate to 16 bits.
    function automatic sample_t predict_filtered(sample_t x);
        longint acc;
        longint q;
        acc = longint'(coef_mem[0]) * longint'(x);
        for (int i = 1; i < TAPS; i++)
            acc += longint'(coef_mem[i]) * longint'(history[i-1]);
        q = (acc + 64'sd16384) >>> FRAC_BITS;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return sample_t'(q);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                coef_mem[i] = '0;
            for (int i = 0; i < TAPS - 1; i++)
                history[i] = '0;
            filtered_q.delete();
            mismatches   = 0;
            results_seen = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            // Retire results first: a result can never belong to an item
            // accepted on the same edge.
            if (result_ch.valid && result_ch.ready)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("result %0d = %0d with nothing expected",
                                              results_seen, result_ch.filtered_out));
                else
                begin
                    want = filtered_q.pop_front();
                    if (result_ch.filtered_out !== want)
                        report_mismatch($sformatf("result %0d filtered_out = %0d, want %0d",
                                                  results_seen, result_ch.filtered_out,
                                                  want));
                end
                results_seen++;
            end

            if (sample_ch.valid && sample_ch.ready)
            begin
                if (sample_ch.mode == MODE_COEF)
                begin
                    // Drop writes beyond the last tap.
                    if (sample_ch.coef_index < TAPS)
                        coef_mem[sample_ch.coef_index] = sample_ch.coef_value;
                end
                else
                begin
                    filtered_q.push_back(predict_filtered(sample_ch.sample_in));
                    for (int i = TAPS - 2; i > 0; i--)
                        history[i] = history[i-1];
                    history[0] = sample_ch.sample_in;
                end
            end

            fail_count <= mismatches;
            pending    <= filtered_q.size();
        end
    end

endmodule : fir_result_checker

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top-level testbench for the direct-form FIR filter: drives coefficient and
// sample transfers with random gaps, stalls the result channel at random, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb import fir_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS        = FIR_TAPS_DEF;
    localparam int ITEM_TARGET = 950;
    // Extra wait after the final drain, allowed for stragglers.
    localparam int TAIL_CYCLES = 2 * TAPS + 20;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_sent;
    bit          src_steady;   // when set, the sender inserts no gaps

    fir_in_if  sample_ch ();
    fir_out_if result_ch ();

    fir_filter_direct_form #(
        .TAPS      (TAPS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    fir_result_checker #(
        .TAPS       (TAPS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Draw a Q1.15 value: extremes and zero now and then, otherwise either a
    // small value (keeps the sum out of saturation) or anything at all.
    function automatic sample_t draw_q15(bit narrow);
        int pick;
        int v;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       v = 32767;
            1:       v = -32768;
            2:       v = 0;
            3, 4, 5: v = int'($urandom_range(0, 4095)) - 2048;
            default:
                if (narrow)
                    v = int'($urandom_range(0, 4095)) - 2048;
                else
                    v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return sample_t'(v);
    endfunction

    // Hold the item on the channel until it transfers. Valid stays high on
    // exit so back-to-back items need not drop valid between them.
    task automatic push_item(logic mode, sample_t x, coef_idx_t idx, sample_t cv);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.mode       <= mode;
        sample_ch.sample_in  <= x;
        sample_ch.coef_index <= idx;
        sample_ch.coef_value <= cv;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        // Dropped coefficient writes do nothing, so leave them out of the count.
        if (mode == MODE_FILTER || idx < TAPS)
            items_sent++;
    endtask

    // Unused fields carry random junk so the block is seen to ignore them.
    task automatic push_sample(sample_t x);
        push_item(MODE_FILTER, x, coef_idx_t'($urandom_range(0, 63)),
                  sample_t'($urandom_range(0, 65535)));
    endtask

    task automatic push_coef(coef_idx_t idx, sample_t cv);
        push_item(MODE_COEF, sample_t'($urandom_range(0, 65535)), idx, cv);
    endtask

    // Stop sending and hold until every predicted result has come back.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Result side: hold ready low for a random stall before each transfer, with
    // occasional stretches of no stall at all.
    initial
    begin
        int stall;
        bit sink_steady;
        sink_steady = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_steady = ($urandom_range(0, 2) == 0);
            stall = sink_steady ? 0 : $urandom_range(0, 3);
            repeat (stall)
            begin
                result_ch.ready <= 1'b0;
                @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int  burst;
        bit  narrow;
        items_sent = 0;
        src_steady = 1'b0;
        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.mode       <= MODE_FILTER;
        sample_ch.sample_in  <= '0;
        sample_ch.coef_index <= '0;
        sample_ch.coef_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cleared coefficient store: full-scale samples must filter to zero.
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);

        // Load the first two taps at full scale and the last at the most
        // negative value; writes at index 63 and at the first index past the
        // last tap must be dropped.
        push_coef(0, 16'sh7FFF);
        push_coef(1, 16'sh7FFF);
        push_coef(coef_idx_t'(TAPS - 1), 16'sh8000);
        push_coef(63, 16'sh3039);
        push_coef(coef_idx_t'(TAPS), 16'shFFFF);

        // Two full-scale taps: saturate high, then saturate low.
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh8000);

        // Rounding ties: +0.5 LSB rounds up, -0.5 LSB rounds toward zero.
        push_coef(0, 16'sh0001);
        push_coef(1, 16'sh0000);
        push_sample(16'sh4000);
        push_sample(16'shC000);

        // Most negative times most negative: 2^30 overflows Q1.15.
        push_coef(0, 16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh0001);
        push_sample(16'shFFFF);

        // Let the pipeline run dry once before the random part.
        wait_for_drain();

        // Random part: segments of mixed traffic, often preceded by a fresh
        // load of the whole coefficient set.
        while (items_sent < ITEM_TARGET)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                narrow = ($urandom_range(0, 3) != 0);
                for (int k = 0; k < TAPS; k++)
                    push_coef(coef_idx_t'(k), draw_q15(narrow));
            end
            burst = $urandom_range(20, 60);
            repeat (burst)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_coef(coef_idx_t'($urandom_range(0, 63)),
                              draw_q15($urandom_range(0, 1)));
                else
                    push_sample(draw_q15(1'b0));
            end
            if ($urandom_range(0, 5) == 0)
                wait_for_drain();
        end

        // Drain, then give any stray result time to show up.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : tb

FILE: filelist.f
rtl/fir_pkg.sv
rtl/fir_in_if.sv
rtl/fir_out_if.sv
rtl/fir_mac.sv
rtl/fir_filter_direct_form.sv
verif/fir_result_checker.sv
verif/tb.sv
